// ----- hw/rtl/bbpa_pkg.sv -----
// Bark band power accumulator: shared sizes, operation codes and types.
// Used by every module of the block except the generic RAM.
package bbpa_pkg;

  localparam int NUM_CELLS   = 128;
  localparam int NUM_BANDS   = 100;
  localparam int TABLE_DEPTH = NUM_BANDS + 3;

  localparam int CELL_W     = $clog2(NUM_CELLS);
  localparam int BANK_DEPTH = NUM_CELLS / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int TAB_AW     = $clog2(TABLE_DEPTH);

  localparam int POW_W   = 56;   // cumulative power store
  localparam int BAND_W  = 57;   // band power result
  localparam int TOTAL_W = 55;   // total power result
  localparam int FRAC_W  = 16;   // Q0.16 interpolation fraction
  localparam int ECELL_W = 7;    // cell index held in the table
  localparam int SAMP_W  = 16;
  localparam int WGT_W   = 16;
  localparam int SQ_W    = 32;   // re^2 + im^2
  localparam int PROD_W  = SQ_W + WGT_W;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CELL  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    logic [ECELL_W-1:0] cell_idx;
    logic [FRAC_W-1:0]  frac;
  } tab_entry_t;

  // one interpolation launched into the interpolation pipe
  typedef struct packed {
    logic             valid;
    logic             last;   // lower cell is the last one: upper equals lower
    logic [POW_W-1:0] lo;
    logic [POW_W-1:0] hi;
    logic [FRAC_W-1:0] frac;
  } interp_req_t;

endpackage

// ----- hw/rtl/bbpa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/bbpa_interp.sv -----
// Three-stage interpolation pipe: lo + floor((hi - lo) * frac / 2^16).
// Depends on bbpa_pkg.
module bbpa_interp
  import bbpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  interp_req_t       req,
  output logic              res_valid,
  output logic [POW_W-1:0]  res_value
);

  logic              v1, v2, v3;
  logic [POW_W-1:0]  d1, lo1, lo2, part2, val3;
  logic [FRAC_W-1:0] f1;

  logic [POW_W-FRAC_W-1:0] d_hi;
  logic [POW_W-1:0]        hi_prod;
  logic [2*FRAC_W-1:0]     lo_prod;

  assign d_hi    = d1[POW_W-1:FRAC_W];
  assign hi_prod = d_hi * f1;
  assign lo_prod = d1[FRAC_W-1:0] * f1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
    end
    // stage 1: difference of neighbouring cumulative values
    d1  <= req.last ? '0 : req.hi - req.lo;
    lo1 <= req.lo;
    f1  <= req.frac;
    // stage 2: split product, exact floor
    part2 <= hi_prod + POW_W'(lo_prod[2*FRAC_W-1:FRAC_W]);
    lo2   <= lo1;
    // stage 3: interpolated value
    val3 <= lo2 + part2;
  end

  assign res_valid = v3;
  assign res_value = val3;

endmodule

// ----- hw/rtl/bark_band_power_accumulator_unit.sv -----
// Bark band power accumulator, top level: sequencer, spectrum accumulation,
// output register. Depends on bbpa_pkg, bbpa_ram and bbpa_interp.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall  | operation, table_entry, entry_cell,
//           |                      | entry_fraction, cell_req, re, im, weight,
//           |                      | band
//   out     | out_valid / out_stall| band_power, total_power
//
// One request is worked on at a time. A table write is done at acceptance; a
// spectrum cell is squared at acceptance, weight multiplied and accumulated
// next cycle. A band read does one interpolation for bands 0 and 1 and two
// otherwise: each interpolation is a table read, a paired cumulative read and
// the 3-stage interpolation pipe. A read with an out-of-range band gives zero,
// a read before a complete frame gives no result. Reset is synchronous; no
// clearing pass is needed. A result waits in the output register; a read
// reaching it while the previous result is still stalled holds until it goes.
module bark_band_power_accumulator_unit
  import bbpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic [7:0]               table_entry,
  input  logic [ECELL_W-1:0]       entry_cell,
  input  logic [FRAC_W-1:0]        entry_fraction,
  input  logic [6:0]               cell_req,
  input  logic signed [SAMP_W-1:0] re,
  input  logic signed [SAMP_W-1:0] im,
  input  logic [WGT_W-1:0]         weight,
  input  logic [7:0]               band,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [BAND_W-1:0] band_power,
  output logic [TOTAL_W-1:0]       total_power
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ACC  = 6'b000010,   // weight multiply, accumulate, store cell
    S_TAB  = 6'b000100,   // table entry back, issue cumulative reads
    S_CP   = 6'b001000,   // cumulative pair back, launch interpolation
    S_INT  = 6'b010000,   // wait for interpolated value
    S_OUT  = 6'b100000    // hand result to output register
  } state_t;

  state_t state, state_next;

  // frame state
  logic [POW_W-1:0]  running_sum;
  logic [CELL_W-1:0] next_cell;
  logic              frame_valid;

  // cell request held for the accumulate cycle
  logic [SQ_W-1:0]   sq;
  logic [WGT_W-1:0]  w_reg;
  logic [CELL_W-1:0] k_reg;
  logic              dc;

  // band read context
  logic [7:0]        band_reg;
  logic              second;
  logic [BAND_W-1:0] acc;
  logic              par_odd;
  logic              last;
  logic [FRAC_W-1:0] frac_reg;

  logic in_acc;
  op_t  op;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign op       = op_t'(operation);

  // ---------------------------------------------------------------------
  // Cell acceptance: order check and squares straight from the ports
  // ---------------------------------------------------------------------
  logic [CELL_W-1:0] k_in;
  logic              cell_ok;
  logic signed [SQ_W-1:0] re_sq, im_sq;
  logic [SQ_W-1:0]   sq_in;

  assign k_in    = CELL_W'(cell_req);
  assign cell_ok = (int'(cell_req) < NUM_CELLS) &&
                   ((k_in == '0) || ((next_cell != '0) && (k_in == next_cell)));
  assign re_sq   = re * re;
  assign im_sq   = im * im;
  assign sq_in   = $unsigned(re_sq) + ((k_in == '0) ? '0 : $unsigned(im_sq));

  logic [PROD_W-1:0] prod;
  logic [POW_W-1:0]  sum_next;
  assign prod     = sq * w_reg;
  // DC cell restarts the sum with half its power
  assign sum_next = dc ? POW_W'(prod >> 1) : running_sum + POW_W'(prod);

  // ---------------------------------------------------------------------
  // Interpolation table
  // ---------------------------------------------------------------------
  tab_entry_t        tab_wdata, tab_q;
  logic              tab_we, tab_re;
  logic [TAB_AW-1:0] tab_raddr;
  logic              int_first_done;
  logic [8:0]        band_inc;

  assign tab_wdata.cell_idx = entry_cell;
  assign tab_wdata.frac     = entry_fraction;
  assign tab_we = in_acc && (op == OP_WRITE) && (int'(table_entry) < TABLE_DEPTH);

  // issue table read for entry b+1 at acceptance, b-1 after the first value
  logic read_ok;
  assign read_ok  = in_acc && (op == OP_READ) && frame_valid &&
                    (int'(band) < NUM_BANDS);
  assign band_inc = {1'b0, band} + 9'd1;

  logic              int_done;
  logic [POW_W-1:0]  int_value;
  assign int_first_done = (state == S_INT) && int_done && !second && (band_reg >= 8'd2);

  assign tab_re    = read_ok || int_first_done;
  assign tab_raddr = (state == S_IDLE) ? TAB_AW'(band_inc) : TAB_AW'(band_reg - 8'd1);

  bbpa_ram #(
    .WIDTH ($bits(tab_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_tab_ram (
    .clk     (clk),
    .wr_en   (tab_we),
    .wr_addr (TAB_AW'(table_entry)),
    .wr_data (tab_wdata),
    .rd_en   (tab_re),
    .rd_addr (tab_raddr),
    .rd_data (tab_q)
  );

  // ---------------------------------------------------------------------
  // Cumulative power store, split into even and odd cell banks so that
  // cells c and c+1 come back together. Entry NUM_CELLS mirrors the last
  // cell and is not stored: the last cell interpolates to itself.
  // ---------------------------------------------------------------------
  logic [CELL_W-1:0]  c_cl;
  logic [CELL_W:0]    c_inc;
  logic [BANK_AW-1:0] ev_raddr, od_raddr, bank_waddr;
  logic [POW_W-1:0]   ev_q, od_q;
  logic               bank_re, ev_we, od_we;

  assign c_cl  = (int'(tab_q.cell_idx) >= NUM_CELLS) ? CELL_W'(NUM_CELLS - 1)
                                                     : CELL_W'(tab_q.cell_idx);
  assign c_inc = {1'b0, c_cl} + 1'b1;
  assign ev_raddr   = BANK_AW'(c_inc >> 1);
  assign od_raddr   = c_cl[CELL_W-1:1];
  assign bank_re    = (state == S_TAB);
  assign bank_waddr = k_reg[CELL_W-1:1];
  assign ev_we      = (state == S_ACC) && !k_reg[0];
  assign od_we      = (state == S_ACC) &&  k_reg[0];

  bbpa_ram #(
    .WIDTH (POW_W),
    .DEPTH (BANK_DEPTH)
  ) u_even_ram (
    .clk     (clk),
    .wr_en   (ev_we),
    .wr_addr (bank_waddr),
    .wr_data (sum_next),
    .rd_en   (bank_re),
    .rd_addr (ev_raddr),
    .rd_data (ev_q)
  );

  bbpa_ram #(
    .WIDTH (POW_W),
    .DEPTH (BANK_DEPTH)
  ) u_odd_ram (
    .clk     (clk),
    .wr_en   (od_we),
    .wr_addr (bank_waddr),
    .wr_data (sum_next),
    .rd_en   (bank_re),
    .rd_addr (od_raddr),
    .rd_data (od_q)
  );

  // ---------------------------------------------------------------------
  // Interpolation pipe
  // ---------------------------------------------------------------------
  interp_req_t ireq;
  assign ireq.valid = (state == S_CP);
  assign ireq.last  = last;
  assign ireq.lo    = par_odd ? od_q : ev_q;
  assign ireq.hi    = par_odd ? ev_q : od_q;
  assign ireq.frac  = frac_reg;

  bbpa_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .req       (ireq),
    .res_valid (int_done),
    .res_value (int_value)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if ((op == OP_CELL) && cell_ok) begin
            state_next = S_ACC;
          end else if ((op == OP_READ) && frame_valid) begin
            state_next = read_ok ? S_TAB : S_OUT;
          end
        end
      end
      S_ACC: state_next = S_IDLE;
      S_TAB: state_next = S_CP;
      S_CP:  state_next = S_INT;
      S_INT: begin
        if (int_done) begin
          state_next = int_first_done ? S_TAB : S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      running_sum <= '0;
      next_cell   <= '0;
      frame_valid <= 1'b0;
      out_valid   <= 1'b0;
      second      <= 1'b0;
    end else begin
      state <= state_next;

      if (in_acc && (op == OP_CELL) && cell_ok && (k_in == '0)) begin
        frame_valid <= 1'b0;
      end

      if (state == S_ACC) begin
        running_sum <= sum_next;
        if (k_reg == CELL_W'(NUM_CELLS - 1)) begin
          frame_valid <= 1'b1;
          next_cell   <= '0;
        end else begin
          next_cell <= k_reg + 1'b1;
        end
      end

      if (read_ok) begin
        second <= 1'b0;
      end else if (int_first_done) begin
        second <= 1'b1;
      end

      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sq       <= sq_in;
      w_reg    <= weight;
      k_reg    <= k_in;
      dc       <= (k_in == '0);
      band_reg <= band;
      acc      <= '0;   // out-of-range band reads as zero
    end

    if (state == S_TAB) begin
      par_odd  <= c_cl[0];
      last     <= (c_cl == CELL_W'(NUM_CELLS - 1));
      frac_reg <= tab_q.frac;
    end

    if ((state == S_INT) && int_done) begin
      if (!second) begin
        acc <= BAND_W'(int_value);
      end else begin
        acc <= acc - BAND_W'(int_value);
      end
    end

    if ((state == S_OUT) && out_free) begin
      band_power  <= acc;
      total_power <= running_sum[TOTAL_W-1:0];
    end
  end

endmodule
